FILE: design/fpbt_pkg.sv
package fpbt_pkg;

    // Width of every cell coordinate and pointer field
    localparam int FIELD_W = 7;
    // Width of the running basin count
    localparam int COUNT_W = 13;
    // Width of the walk step counter and the walk limit (rows times columns)
    localparam int STEP_W = 2 * FIELD_W;
    // One memory word holds the next column over the next row
    localparam int PTR_W = 2 * FIELD_W;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Configuration register reset values
    localparam logic [FIELD_W-1:0] RST_GRID_ROWS   = FIELD_W'(64);
    localparam logic [FIELD_W-1:0] RST_GRID_COLS   = FIELD_W'(64);
    localparam logic [FIELD_W-1:0] RST_STATION_COL = FIELD_W'(1);
    localparam logic [FIELD_W-1:0] RST_STATION_ROW = FIELD_W'(1);

    // APB register map, word index
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_GRID_ROWS   = 2'd0;
    localparam logic [1:0] REG_GRID_COLS   = 2'd1;
    localparam logic [1:0] REG_STATION_COL = 2'd2;
    localparam logic [1:0] REG_STATION_ROW = 2'd3;

    // Item kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TRACE = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] grid_rows;
        logic [FIELD_W-1:0] grid_cols;
        logic [FIELD_W-1:0] station_col;
        logic [FIELD_W-1:0] station_row;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_EVAL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the transaction fields
        logic load_write;  // write the latched pointer
        logic rd_issue;    // read the pointer of the current cell
        logic advance;     // step to the pointed cell
        logic finish;      // emit the result
        logic finish_hit;  // result is a basin hit
        logic finish_load; // result closes a load
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic first;       // walk still at its start cell
        logic in_grid;     // current cell inside the grid in use
        logic at_station;  // current cell is the station
        logic ptr_zero;    // pointer read has no outflow
        logic step_limit;  // walk has used up its step budget
    } status_t;

endpackage

FILE: design/fpbt_ram.sv
module fpbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/fpbt_cfg.sv
module fpbt_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fpbt_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output fpbt_pkg::cfg_t                 cfg
);

    fpbt_pkg::cfg_t cfg_reg;
    fpbt_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = paddr[3:2];

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_idx)
                fpbt_pkg::REG_GRID_ROWS:   cfg_next.grid_rows   = pwdata[fpbt_pkg::FIELD_W-1:0];
                fpbt_pkg::REG_GRID_COLS:   cfg_next.grid_cols   = pwdata[fpbt_pkg::FIELD_W-1:0];
                fpbt_pkg::REG_STATION_COL: cfg_next.station_col = pwdata[fpbt_pkg::FIELD_W-1:0];
                fpbt_pkg::REG_STATION_ROW: cfg_next.station_row = pwdata[fpbt_pkg::FIELD_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_rows   <= fpbt_pkg::RST_GRID_ROWS;
            cfg_reg.grid_cols   <= fpbt_pkg::RST_GRID_COLS;
            cfg_reg.station_col <= fpbt_pkg::RST_STATION_COL;
            cfg_reg.station_row <= fpbt_pkg::RST_STATION_ROW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (wr_idx)
            fpbt_pkg::REG_GRID_ROWS:   prdata = 32'(cfg_reg.grid_rows);
            fpbt_pkg::REG_GRID_COLS:   prdata = 32'(cfg_reg.grid_cols);
            fpbt_pkg::REG_STATION_COL: prdata = 32'(cfg_reg.station_col);
            fpbt_pkg::REG_STATION_ROW: prdata = 32'(cfg_reg.station_row);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/fpbt_ctrl.sv
module fpbt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                action,
    input  fpbt_pkg::status_t   status,
    output fpbt_pkg::cmd_t      cmd,
    output logic                busy
);

    fpbt_pkg::state_t state_reg;
    fpbt_pkg::state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpbt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (action == fpbt_pkg::ACT_TRACE) ? fpbt_pkg::ST_CHECK
                                                                 : fpbt_pkg::ST_LOAD;
                end
            end
            fpbt_pkg::ST_LOAD:
            begin
                state_next = fpbt_pkg::ST_IDLE;
            end
            fpbt_pkg::ST_CHECK:
            begin
                if (status.first)
                begin
                    state_next = status.in_grid ? fpbt_pkg::ST_EVAL : fpbt_pkg::ST_IDLE;
                end
                else if (status.at_station || !status.in_grid)
                begin
                    state_next = fpbt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = fpbt_pkg::ST_EVAL;
                end
            end
            fpbt_pkg::ST_EVAL:
            begin
                if (status.ptr_zero || (status.first && status.at_station) || status.step_limit)
                begin
                    state_next = fpbt_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = fpbt_pkg::ST_CHECK;
                end
            end
            default:
            begin
                state_next = fpbt_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            fpbt_pkg::ST_IDLE:
            begin
                cmd.capture = start;
            end
            fpbt_pkg::ST_LOAD:
            begin
                cmd.load_write  = 1'b1;
                cmd.finish      = 1'b1;
                cmd.finish_load = 1'b1;
            end
            fpbt_pkg::ST_CHECK:
            begin
                if (status.first)
                begin
                    cmd.rd_issue = status.in_grid;
                    cmd.finish   = !status.in_grid;
                end
                else if (status.at_station)
                begin
                    cmd.finish     = 1'b1;
                    cmd.finish_hit = 1'b1;
                end
                else if (!status.in_grid)
                begin
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end
            fpbt_pkg::ST_EVAL:
            begin
                if (status.ptr_zero)
                begin
                    cmd.finish = 1'b1;
                end
                else if (status.first && status.at_station)
                begin
                    cmd.finish     = 1'b1;
                    cmd.finish_hit = 1'b1;
                end
                else if (status.step_limit)
                begin
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != fpbt_pkg::ST_IDLE);

endmodule

FILE: design/fpbt_dp.sv
module fpbt_dp #(
    parameter int MAX_ROWS = fpbt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = fpbt_pkg::DEF_MAX_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fpbt_pkg::cfg_t                      cfg,
    input  fpbt_pkg::cmd_t                      cmd,
    output fpbt_pkg::status_t                   status,
    input  logic [fpbt_pkg::FIELD_W-1:0]        cell_row,
    input  logic [fpbt_pkg::FIELD_W-1:0]        cell_col,
    input  logic [fpbt_pkg::FIELD_W-1:0]        next_col,
    input  logic [fpbt_pkg::FIELD_W-1:0]        next_row,
    output logic                                done,
    output logic                                in_basin,
    output logic [fpbt_pkg::COUNT_W-1:0]        basin_index,
    output logic [fpbt_pkg::FIELD_W-1:0]        out_row,
    output logic [fpbt_pkg::FIELD_W-1:0]        out_col
);

    localparam int FW    = fpbt_pkg::FIELD_W;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = AW + FW + 1;
    localparam int RW    = ($clog2(MAX_ROWS + 1) > FW) ? $clog2(MAX_ROWS + 1) : FW;
    localparam int CW    = ($clog2(MAX_COLS + 1) > FW) ? $clog2(MAX_COLS + 1) : FW;
    localparam logic [fpbt_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    logic [FW-1:0]                cur_r_reg, cur_c_reg;
    logic [FW-1:0]                echo_r_reg, echo_c_reg;
    logic [FW-1:0]                ld_col_reg, ld_row_reg;
    logic                         first_reg;
    logic [fpbt_pkg::STEP_W-1:0]  steps_reg, limit_reg;
    logic [fpbt_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         done_reg, hit_reg;
    logic [fpbt_pkg::COUNT_W-1:0] index_reg;

    logic [FW-1:0]                rows_eff, cols_eff;
    logic [IW-1:0]                addr_wide;
    logic [AW-1:0]                addr;
    logic                         ld_ok;
    logic [fpbt_pkg::PTR_W-1:0]   rd_data;
    logic [FW-1:0]                ptr_col, ptr_row;

    // Clamp the grid size to the store size
    assign rows_eff = (RW'(cfg.grid_rows) > RW'(MAX_ROWS)) ? FW'(MAX_ROWS) : cfg.grid_rows;
    assign cols_eff = (CW'(cfg.grid_cols) > CW'(MAX_COLS)) ? FW'(MAX_COLS) : cfg.grid_cols;

    // Row-major cell address of the current cell
    assign addr_wide = (IW'(cur_r_reg) - IW'(1)) * IW'(MAX_COLS) + (IW'(cur_c_reg) - IW'(1));
    assign addr      = addr_wide[AW-1:0];

    // A load writes only inside the store
    assign ld_ok = (cur_r_reg != '0) && (RW'(cur_r_reg) <= RW'(MAX_ROWS))
                && (cur_c_reg != '0) && (CW'(cur_c_reg) <= CW'(MAX_COLS));

    fpbt_ram #(
        .WIDTH (fpbt_pkg::PTR_W),
        .DEPTH (CELLS)
    ) u_ptr_ram (
        .clk     (clk),
        .wr_en   (cmd.load_write && ld_ok),
        .wr_addr (addr),
        .wr_data ({ld_col_reg, ld_row_reg}),
        .rd_en   (cmd.rd_issue),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    assign ptr_col = rd_data[fpbt_pkg::PTR_W-1:FW];
    assign ptr_row = rd_data[FW-1:0];

    // Status for the controller
    assign status.first      = first_reg;
    assign status.in_grid    = (cur_r_reg != '0) && (cur_r_reg <= rows_eff)
                            && (cur_c_reg != '0) && (cur_c_reg <= cols_eff);
    assign status.at_station = (cur_c_reg == cfg.station_col) && (cur_r_reg == cfg.station_row);
    assign status.ptr_zero   = (ptr_col == '0);
    assign status.step_limit = (steps_reg >= limit_reg);

    // Walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_r_reg  <= cell_row;
            cur_c_reg  <= cell_col;
            echo_r_reg <= cell_row;
            echo_c_reg <= cell_col;
            ld_col_reg <= next_col;
            ld_row_reg <= next_row;
            first_reg  <= 1'b1;
            steps_reg  <= '0;
            limit_reg  <= fpbt_pkg::STEP_W'(rows_eff) * fpbt_pkg::STEP_W'(cols_eff);
        end
        else if (cmd.advance)
        begin
            cur_r_reg <= ptr_row;
            cur_c_reg <= ptr_col;
            first_reg <= 1'b0;
            steps_reg <= steps_reg + 1'b1;
        end
    end

    // Basin count: clear on load, saturating increment on hit
    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish)
        begin
            if (cmd.finish_load)
            begin
                count_next = '0;
            end
            else if (cmd.finish_hit && (count_reg != COUNT_MAX))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            hit_reg   <= cmd.finish_hit;
            index_reg <= count_next;
        end
    end

    assign done        = done_reg;
    assign in_basin    = hit_reg;
    assign basin_index = index_reg;
    assign out_row     = echo_r_reg;
    assign out_col     = echo_c_reg;

endmodule

FILE: design/flow_path_basin_tracer_top.sv
// Flow path basin tracer. A transaction is taken when start is high and busy is low; its
// result appears on in_basin, basin_index, out_row and out_col for exactly one cycle with
// done high, and cannot be held off, so the receiver must take it in that cycle. A load
// passes through the LOAD state before its result. Each pointer followed passes through
// CHECK, which checks the cell and issues a read of the pointer memory, and EVAL, which
// evaluates the registered read data. A trace ends in CHECK when it starts outside the
// grid or a followed pointer lands on the station or leaves the grid, and in EVAL when it
// ends on a zero pointer, on the step limit or at a start cell that is the station. At
// most rows*cols pointers are followed. A new transaction can be accepted in the cycle
// that presents the previous result. The pointer memory is not cleared after reset: trace
// only over cells that have been loaded.
module flow_path_basin_tracer_top #(
    parameter int MAX_ROWS = fpbt_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = fpbt_pkg::DEF_MAX_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fpbt_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [fpbt_pkg::FIELD_W-1:0]      cell_row,
    input  logic [fpbt_pkg::FIELD_W-1:0]      cell_col,
    input  logic [fpbt_pkg::FIELD_W-1:0]      next_col,
    input  logic [fpbt_pkg::FIELD_W-1:0]      next_row,
    output logic                              done,
    output logic                              in_basin,
    output logic [fpbt_pkg::COUNT_W-1:0]      basin_index,
    output logic [fpbt_pkg::FIELD_W-1:0]      out_row,
    output logic [fpbt_pkg::FIELD_W-1:0]      out_col
);

    fpbt_pkg::cfg_t    cfg;
    fpbt_pkg::cmd_t    cmd;
    fpbt_pkg::status_t status;

    fpbt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpbt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    fpbt_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .next_col    (next_col),
        .next_row    (next_row),
        .done        (done),
        .in_basin    (in_basin),
        .basin_index (basin_index),
        .out_row     (out_row),
        .out_col     (out_col)
    );

    // An accepted transaction occupies the block in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result only follows a cycle of work
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // A basin hit always reports a non-zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_basin) |-> (basin_index != '0))
        else $error("basin hit reported with a zero count");

endmodule
